>>> hw/rtl/vmand_pkg.sv
`timescale 1ns / 1ps

package vmand_pkg;

  // Machine dimensions.
  localparam int ARENA_BYTES      = 4096;
  localparam int REGS_PER_PROCESS = 16;
  localparam int PROCESSES        = 4;
  localparam int INDEX_WINDOW     = 512;

  localparam int AR_AW    = $clog2(ARENA_BYTES);
  localparam int RF_DEPTH = PROCESSES * REGS_PER_PROCESS;
  localparam int RF_AW    = $clog2(RF_DEPTH);
  localparam int PROC_W   = $clog2(PROCESSES);
  localparam int WIN_W    = $clog2(INDEX_WINDOW);

  // Field widths of the channel words.
  localparam int OPC_W  = 2;
  localparam int PID_W  = 2;
  localparam int MODE_W = 2;
  localparam int WORD_W = 32;
  localparam int REGN_W = 8;
  localparam int PC_W   = 12;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 2;
  localparam int OFF_W  = 16;

  localparam int BYTES_PER_WORD = WORD_W / BYTE_W;
  localparam int BCNT_W         = $clog2(BYTES_PER_WORD);

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD_BYTE = 2'd0,
    OP_LOAD_REG  = 2'd1,
    OP_AND       = 2'd2,
    OP_UNUSED    = 2'd3
  } opcode_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ZERO     = 2'd0,
    MODE_REG      = 2'd1,
    MODE_DIRECT   = 2'd2,
    MODE_INDIRECT = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_EXEC   = 2'd0,
    ST_REJECT = 2'd1,
    ST_LOAD   = 2'd2
  } status_t;

  // Program steps of the sequencer.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD_BYTE,
    S_LOAD_REG,
    S_CHECK,
    S_OP_START,
    S_REG_CAP,
    S_IND_BYTE,
    S_OPND_END,
    S_WRITEBACK,
    S_REJECT,
    S_RESULT
  } step_t;

  // Datapath action selected by a control word.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_ACCEPT,
    ACT_ARENA_WR,
    ACT_REG_WR,
    ACT_OP_ISSUE,
    ACT_REG_CAP,
    ACT_BYTE_IN,
    ACT_OPND_END,
    ACT_WRITEBACK,
    ACT_REJECT,
    ACT_EMIT
  } act_t;

  // Branch condition selected by a control word.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_BAD,
    C_MODE,
    C_MORE_BYTES,
    C_FIRST,
    C_OUT_FREE,
    C_CLEAR_MORE
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t on_true;
    step_t on_false;
  } uword_t;

  // Control store: one control word per step.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    unique case (s)
      S_CLEAR:     w = '{act: ACT_CLEAR,     cond: C_CLEAR_MORE, on_true: S_CLEAR,
                         on_false: S_IDLE};
      S_IDLE:      w = '{act: ACT_ACCEPT,    cond: C_DISPATCH,   on_true: S_IDLE,
                         on_false: S_IDLE};
      S_LOAD_BYTE: w = '{act: ACT_ARENA_WR,  cond: C_ALWAYS,     on_true: S_RESULT,
                         on_false: S_RESULT};
      S_LOAD_REG:  w = '{act: ACT_REG_WR,    cond: C_ALWAYS,     on_true: S_RESULT,
                         on_false: S_RESULT};
      S_CHECK:     w = '{act: ACT_NONE,      cond: C_BAD,        on_true: S_REJECT,
                         on_false: S_OP_START};
      S_OP_START:  w = '{act: ACT_OP_ISSUE,  cond: C_MODE,       on_true: S_OPND_END,
                         on_false: S_OPND_END};
      S_REG_CAP:   w = '{act: ACT_REG_CAP,   cond: C_ALWAYS,     on_true: S_OPND_END,
                         on_false: S_OPND_END};
      S_IND_BYTE:  w = '{act: ACT_BYTE_IN,   cond: C_MORE_BYTES, on_true: S_IND_BYTE,
                         on_false: S_OPND_END};
      S_OPND_END:  w = '{act: ACT_OPND_END,  cond: C_FIRST,      on_true: S_OP_START,
                         on_false: S_WRITEBACK};
      S_WRITEBACK: w = '{act: ACT_WRITEBACK, cond: C_ALWAYS,     on_true: S_RESULT,
                         on_false: S_RESULT};
      S_REJECT:    w = '{act: ACT_REJECT,    cond: C_ALWAYS,     on_true: S_RESULT,
                         on_false: S_RESULT};
      S_RESULT:    w = '{act: ACT_EMIT,      cond: C_OUT_FREE,   on_true: S_IDLE,
                         on_false: S_RESULT};
      default:     w = '{act: ACT_NONE,      cond: C_ALWAYS,     on_true: S_IDLE,
                         on_false: S_IDLE};
    endcase
    return w;
  endfunction

  // Entry step for each opcode.
  function automatic step_t dispatch(opcode_t op);
    step_t s;
    unique case (op)
      OP_LOAD_BYTE: s = S_LOAD_BYTE;
      OP_LOAD_REG:  s = S_LOAD_REG;
      OP_AND:       s = S_CHECK;
      default:      s = S_RESULT;
    endcase
    return s;
  endfunction

  // Step that follows operand issue, by operand kind.
  function automatic step_t mode_entry(mode_t m);
    step_t s;
    unique case (m)
      MODE_REG:      s = S_REG_CAP;
      MODE_INDIRECT: s = S_IND_BYTE;
      default:       s = S_OPND_END;
    endcase
    return s;
  endfunction

  function automatic logic reg_ok(logic [REGN_W-1:0] r);
    return (r != '0) && (32'(r) <= REGS_PER_PROCESS);
  endfunction

  function automatic logic [RF_AW-1:0] reg_index(logic [PROC_W-1:0] p,
                                                 logic [REGN_W-1:0] r);
    return RF_AW'(32'(p) * REGS_PER_PROCESS + 32'(r) - 32'd1);
  endfunction

endpackage

>>> hw/rtl/vmand_if.sv
`timescale 1ns / 1ps

interface vmand_in_if;
  import vmand_pkg::*;

  logic              valid;
  logic              ready;
  logic [OPC_W-1:0]  opcode;
  logic [PID_W-1:0]  process_id;
  logic [MODE_W-1:0] mode_first;
  logic [WORD_W-1:0] arg_first;
  logic [MODE_W-1:0] mode_second;
  logic [WORD_W-1:0] arg_second;
  logic [REGN_W-1:0] dest_reg;
  logic [PC_W-1:0]   prog_counter;
  logic [PC_W-1:0]   mem_addr;
  logic [BYTE_W-1:0] mem_byte;
  logic [WORD_W-1:0] reg_value;

  modport source (
    output valid, opcode, process_id, mode_first, arg_first, mode_second, arg_second,
           dest_reg, prog_counter, mem_addr, mem_byte, reg_value,
    input  ready
  );

  modport sink (
    input  valid, opcode, process_id, mode_first, arg_first, mode_second, arg_second,
           dest_reg, prog_counter, mem_addr, mem_byte, reg_value,
    output ready
  );
endinterface

interface vmand_out_if;
  import vmand_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [WORD_W-1:0] result_value;
  logic              carry_flag;

  modport source (
    output valid, status, result_value, carry_flag,
    input  ready
  );

  modport sink (
    input  valid, status, result_value, carry_flag,
    output ready
  );
endinterface

>>> hw/rtl/vm_and_instruction_execute_top.sv
// Sequence: a load passes accept, its load step and the result step; an AND passes a check,
//   then per operand an issue step, a capture step for a register, one byte step per byte for
//   an indirect operand, and an operand end, then writeback and result; a rejection passes check,
//   reject and result. Flow: one word at a time; the next is taken once its result is registered.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to all 4096 arena
//   bytes before the first input word is accepted.
`timescale 1ns / 1ps

module vm_and_instruction_execute_top (
  input logic        clk,
  input logic        rst_n,
  vmand_in_if.sink   in_ch,
  vmand_out_if.source out_ch
);
  import vmand_pkg::*;

  // Sequencer state: the step counter addresses the control store, and each
  // control word names one datapath action and one branch condition.
  step_t  upc_r, upc_nxt;
  uword_t uw;
  logic   cond_hit;
  logic   in_fire;
  logic   out_free;

  // Latched input word.
  logic [OPC_W-1:0]  opc_r;
  logic [PROC_W-1:0] proc_r;
  logic [MODE_W-1:0] m1_r, m2_r;
  logic [WORD_W-1:0] a1_r, a2_r;
  logic [REGN_W-1:0] dst_r;
  logic [PC_W-1:0]   pc_r;
  logic [PC_W-1:0]   maddr_r;
  logic [BYTE_W-1:0] mbyte_r;
  logic [WORD_W-1:0] rval_r;

  // Operand datapath.
  logic              sel_r;
  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] opa_r;
  logic [WORD_W-1:0] res_r;
  status_t           stat_r;
  logic [BCNT_W-1:0] bcnt_r;
  logic [AR_AW-1:0]  addr_r;
  logic [AR_AW-1:0]  clr_r;
  logic [PROCESSES-1:0] carry_r;

  mode_t             cur_mode;
  logic [WORD_W-1:0] cur_arg;
  logic              item_ok;

  // Indirect address generation.
  logic [OFF_W-1:0]  off;
  logic [OFF_W-1:0]  mag;
  logic [AR_AW-1:0]  rem_ext;
  logic [AR_AW-1:0]  ind_base;

  // Arena memory, one write and one registered read port.
  logic [BYTE_W-1:0] arena_mem [ARENA_BYTES];
  logic              ar_we;
  logic [AR_AW-1:0]  ar_waddr;
  logic [BYTE_W-1:0] ar_wdata;
  logic [AR_AW-1:0]  ar_raddr;
  logic [BYTE_W-1:0] ar_q_r;

  // Register file memory; the valid bits stand in for its reset to zero.
  logic [WORD_W-1:0]   rf_mem [RF_DEPTH];
  logic [RF_DEPTH-1:0] rf_valid_r;
  logic                rf_we;
  logic [RF_AW-1:0]    rf_waddr;
  logic [WORD_W-1:0]   rf_wdata;
  logic [RF_AW-1:0]    rf_raddr;
  logic [WORD_W-1:0]   rf_q_r;
  logic                rf_vq_r;

  // Output register.
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [WORD_W-1:0] out_value_r;
  logic              out_carry_r;

  assign in_ch.ready         = (upc_r == S_IDLE);
  assign in_fire             = in_ch.valid && in_ch.ready;
  assign out_free            = !out_valid_r || out_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.carry_flag   = out_carry_r;

  // The operand being fetched: the first one, then the second one.
  assign cur_mode = mode_t'(sel_r ? m2_r : m1_r);
  assign cur_arg  = sel_r ? a2_r : a1_r;

  // Every register number in use must lie in 1..REGS_PER_PROCESS, the
  // destination always included.
  assign item_ok = reg_ok(dst_r)
                && !((mode_t'(m1_r) == MODE_REG) && !reg_ok(a1_r[REGN_W-1:0]))
                && !((mode_t'(m2_r) == MODE_REG) && !reg_ok(a2_r[REGN_W-1:0]));

  // The offset is a signed 16-bit value and its remainder truncates toward
  // zero, so the magnitude is reduced and the sign put back. The window and
  // the arena are powers of two: reduction is a bit-select and the wrap is
  // the natural overflow of the address adder.
  always_comb begin
    off     = cur_arg[OFF_W-1:0];
    mag     = off[OFF_W-1] ? (~off + OFF_W'(1)) : off;
    rem_ext = AR_AW'(mag[WIN_W-1:0]);
    if (off[OFF_W-1]) begin
      ind_base = AR_AW'(pc_r) - rem_ext;
    end else begin
      ind_base = AR_AW'(pc_r) + rem_ext;
    end
  end

  // Next step: fetch the control word, test its condition, branch.
  always_comb begin
    uw       = ucode(upc_r);
    cond_hit = 1'b1;
    upc_nxt  = uw.on_true;
    unique case (uw.cond)
      C_ALWAYS: begin
        cond_hit = 1'b1;
        upc_nxt  = uw.on_true;
      end
      C_DISPATCH: begin
        cond_hit = in_fire;
        upc_nxt  = in_fire ? dispatch(opcode_t'(in_ch.opcode)) : uw.on_false;
      end
      C_BAD: begin
        cond_hit = !item_ok;
        upc_nxt  = cond_hit ? uw.on_true : uw.on_false;
      end
      C_MODE: begin
        cond_hit = 1'b1;
        upc_nxt  = mode_entry(cur_mode);
      end
      C_MORE_BYTES: begin
        cond_hit = (bcnt_r != BCNT_W'(BYTES_PER_WORD - 1));
        upc_nxt  = cond_hit ? uw.on_true : uw.on_false;
      end
      C_FIRST: begin
        cond_hit = !sel_r;
        upc_nxt  = cond_hit ? uw.on_true : uw.on_false;
      end
      C_OUT_FREE: begin
        cond_hit = out_free;
        upc_nxt  = cond_hit ? uw.on_true : uw.on_false;
      end
      C_CLEAR_MORE: begin
        cond_hit = (clr_r != '1);
        upc_nxt  = cond_hit ? uw.on_true : uw.on_false;
      end
      default: begin
        cond_hit = 1'b1;
        upc_nxt  = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_CLEAR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // Memory port controls. The arena read address runs one byte ahead of
  // the byte that arrives, so an indirect word streams in at a byte a cycle.
  always_comb begin
    ar_we    = (uw.act == ACT_CLEAR) || (uw.act == ACT_ARENA_WR);
    ar_waddr = (uw.act == ACT_CLEAR) ? clr_r : AR_AW'(maddr_r);
    ar_wdata = (uw.act == ACT_CLEAR) ? '0 : mbyte_r;
    ar_raddr = (uw.act == ACT_OP_ISSUE) ? ind_base : (addr_r + AR_AW'(1));

    rf_we    = ((uw.act == ACT_REG_WR) && reg_ok(dst_r)) || (uw.act == ACT_WRITEBACK);
    rf_waddr = reg_index(proc_r, dst_r);
    rf_wdata = (uw.act == ACT_WRITEBACK) ? res_r : rval_r;
    rf_raddr = reg_index(proc_r, cur_arg[REGN_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (ar_we) begin
      arena_mem[ar_waddr] <= ar_wdata;
    end
    ar_q_r <= arena_mem[ar_raddr];
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    rf_q_r  <= rf_mem[rf_raddr];
    rf_vq_r <= rf_valid_r[rf_raddr];
  end

  // Control state: clearing counter, register valid bits, carries and the
  // output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      rf_valid_r  <= '0;
      carry_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (uw.act == ACT_CLEAR) begin
        clr_r <= clr_r + AR_AW'(1);
      end
      if (rf_we) begin
        rf_valid_r[rf_waddr] <= 1'b1;
      end
      if (uw.act == ACT_WRITEBACK) begin
        carry_r[proc_r] <= (res_r == '0);
      end
      if ((uw.act == ACT_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload is loaded when the result step finds the register free.
  always_ff @(posedge clk) begin
    if ((uw.act == ACT_EMIT) && out_free) begin
      out_status_r <= stat_r;
      out_value_r  <= res_r;
      out_carry_r  <= carry_r[proc_r];
    end
  end

  // Datapath actions. Loads and the unused opcode keep the status and zero
  // value set at accept; only execute and reject overwrite them.
  always_ff @(posedge clk) begin
    unique case (uw.act)
      ACT_ACCEPT: begin
        if (in_fire) begin
          opc_r   <= in_ch.opcode;
          proc_r  <= PROC_W'(in_ch.process_id);
          m1_r    <= in_ch.mode_first;
          a1_r    <= in_ch.arg_first;
          m2_r    <= in_ch.mode_second;
          a2_r    <= in_ch.arg_second;
          dst_r   <= in_ch.dest_reg;
          pc_r    <= in_ch.prog_counter;
          maddr_r <= in_ch.mem_addr;
          mbyte_r <= in_ch.mem_byte;
          rval_r  <= in_ch.reg_value;
          sel_r   <= 1'b0;
          res_r   <= '0;
          stat_r  <= ST_LOAD;
        end
      end
      ACT_OP_ISSUE: begin
        acc_r  <= (cur_mode == MODE_DIRECT) ? cur_arg : '0;
        addr_r <= ind_base;
        bcnt_r <= '0;
      end
      ACT_REG_CAP: begin
        acc_r <= rf_vq_r ? rf_q_r : '0;
      end
      ACT_BYTE_IN: begin
        // Big-endian: earlier bytes move up.
        acc_r  <= {acc_r[WORD_W-BYTE_W-1:0], ar_q_r};
        addr_r <= addr_r + AR_AW'(1);
        bcnt_r <= bcnt_r + BCNT_W'(1);
      end
      ACT_OPND_END: begin
        if (!sel_r) begin
          opa_r <= acc_r;
          sel_r <= 1'b1;
        end else begin
          res_r <= opa_r & acc_r;
        end
      end
      ACT_WRITEBACK: begin
        stat_r <= ST_EXEC;
      end
      ACT_REJECT: begin
        stat_r <= ST_REJECT;
        res_r  <= '0;
      end
      default: begin
      end
    endcase
  end

  // Dispatch uses the opcode on the input port; the latched opcode is kept for
  // the check that execute status is only produced for an AND.
  logic opc_is_and;
  assign opc_is_and = (opcode_t'(opc_r) == OP_AND);

  // A result word only appears out of the result step.
  a_emit_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(upc_r == S_RESULT))
    else $error("output word raised outside the result step");

  // Only an executed AND carries a nonzero value.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != ST_EXEC)) |-> (out_ch.result_value == '0))
    else $error("nonzero value on a load or rejected word");

  // An executed AND reports carry exactly when its value is zero.
  a_carry_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == ST_EXEC)) |->
      (out_ch.carry_flag == (out_ch.result_value == '0)))
    else $error("carry does not match the AND result");

  // Execute status is only ever produced for the AND opcode.
  a_exec_is_and: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_ch.valid) && (out_ch.status == ST_EXEC)) |-> opc_is_and)
    else $error("execute status for an opcode other than AND");

endmodule
